FILE: src/gtpv2_header_ie_parser_top_defines.svh
// ============================================================================
// GTPv2 header/IE parser assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ============================================================================
`ifndef GTPV2_HEADER_IE_PARSER_TOP_DEFINES_SVH
`define GTPV2_HEADER_IE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define GTP2IE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// next-cycle implication
`define GTP2IE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GTP2IE_ASSERT(name, clk, rst_n, prop, msg)
`define GTP2IE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/gtp2ie_pkg.sv
// ============================================================================
// GTPv2 header/IE parser package
// Result record, queue sizing and the kind/status codes shared by the modules.
// ============================================================================
package gtp2ie_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ELEMENT = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // end-of-message status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_SHORT_HDR = 3'd3;
    localparam logic [2:0] ST_EHDR_OVR  = 3'd4;
    localparam logic [2:0] ST_VALUE_OVR = 3'd5;

    localparam logic [2:0] GTP_VERSION  = 3'd2;
    localparam int         HDR_LEN_TEID = 12;
    localparam int         HDR_LEN_SEQ  = 8;
    localparam int         EHDR_LEN     = 4;

    // result queue: two entries per byte at most, one leaves per cycle while popped
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int TDATA_W = 136;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  message_type;
        logic [31:0] tunnel_id;
        logic [23:0] sequence_res;
        logic [16:0] message_length;
        logic [7:0]  element_type;
        logic [3:0]  element_instance;
        logic [15:0] element_length;
        logic [16:0] value_offset;
        logic [5:0]  element_count;
        logic [2:0]  status;
        logic        last_of_run;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: src/gtp2ie_core.sv
// ============================================================================
// GTPv2 header/IE parser core
// Per-byte parse step: header capture, element TLV walk and end status.
// ============================================================================
module gtp2ie_core #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_final,
    output gtp2ie_pkg::push_t    push_o
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_EHDR   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_DRAIN  = 3'd4;

    typedef struct packed {
        logic [2:0]  ph;
        logic        ovr;
        logic [16:0] eend;
    } nxt_t;

    logic [2:0]  phase_reg,    phase_next;
    logic [16:0] pos_reg,      pos_next;
    logic        teid_reg,     teid_next;
    logic [16:0] mend_reg,     mend_next;
    logic [7:0]  mtype_reg,    mtype_next;
    logic [55:0] hlow_reg,     hlow_next;
    logic [23:0] ehb_reg,      ehb_next;
    logic [16:0] eend_reg,     eend_next;
    logic [5:0]  found_reg,    found_next;
    logic [2:0]  pend_reg,     pend_next;

    // boundary after byte p: next element header, or skip to message end
    function automatic nxt_t next_element(input logic [16:0] p, input logic [16:0] mend,
                                          input logic [5:0] fc);
        nxt_t        r;
        logic [17:0] nxt;
        nxt = {1'b0, p} + 18'd1;
        r.ph   = PH_SKIP;
        r.ovr  = 1'b0;
        r.eend = '0;
        if (nxt >= {1'b0, mend} || fc >= 6'(MAX_ELEMENTS)) begin
            r.ph = PH_SKIP;
        end else if (nxt + 18'(gtp2ie_pkg::EHDR_LEN) > {1'b0, mend}) begin
            r.ovr = 1'b1;
        end else begin
            r.ph   = PH_EHDR;
            r.eend = 17'(nxt + 18'(gtp2ie_pkg::EHDR_LEN));
        end
        return r;
    endfunction

    function automatic gtp2ie_pkg::result_t end_result(input logic [5:0] fc,
                                                       input logic [2:0] st);
        gtp2ie_pkg::result_t r;
        r = '0;
        r.kind          = gtp2ie_pkg::KIND_END;
        r.element_count = fc;
        r.status        = st;
        return r;
    endfunction

    always_comb begin
        logic [16:0]         p;
        logic [16:0]         hlast;
        logic [1:0]          idx;
        logic [17:0]         voff;
        logic [17:0]         vend;
        logic [15:0]         el;
        nxt_t                ne;
        gtp2ie_pkg::result_t res;
        logic [1:0]          n;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        teid_next  = teid_reg;
        mend_next  = mend_reg;
        mtype_next = mtype_reg;
        hlow_next  = hlow_reg;
        ehb_next   = ehb_reg;
        eend_next  = eend_reg;
        found_next = found_reg;
        pend_next  = pend_reg;
        push_o     = '0;

        p     = pos_reg;
        hlast = teid_reg ? 17'(gtp2ie_pkg::HDR_LEN_TEID - 1) : 17'(gtp2ie_pkg::HDR_LEN_SEQ - 1);
        idx   = p[1:0] - eend_reg[1:0];
        voff  = {1'b0, p} + 18'd1;
        el    = ehb_reg[15:0];
        vend  = voff + {2'b00, el};
        ne    = '0;
        res   = '0;
        n     = 2'd0;

        if (in_valid && phase_reg != PH_DRAIN) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (p == 17'd0) begin
                        teid_next  = in_byte[3];
                        hlow_next  = {48'd0, in_byte};
                        mtype_next = 8'd0;
                    end else if (p == 17'd1) begin
                        mtype_next = in_byte;
                    end else if (p == 17'd2) begin
                        mend_next = {1'b0, in_byte, 8'd0};
                    end else if (p == 17'd3) begin
                        mend_next = {1'b0, mend_reg[15:8], in_byte} + 17'd4;
                        if (hlow_reg[7:5] != gtp2ie_pkg::GTP_VERSION) begin
                            push_o.first = end_result(6'd0, gtp2ie_pkg::ST_BAD_VER);
                            n          = 2'd1;
                            phase_next = PH_DRAIN;
                        end else begin
                            hlow_next = '0;
                            if (mend_next < {hlast + 17'd1}) begin
                                pend_next  = gtp2ie_pkg::ST_SHORT_HDR;
                                phase_next = PH_SKIP;
                            end
                        end
                    end else begin
                        if (p <= 17'd10) begin
                            hlow_next = {hlow_reg[47:0], in_byte};
                        end
                        if (p == hlast) begin
                            res                = '0;
                            res.kind           = gtp2ie_pkg::KIND_HEADER;
                            res.message_type   = mtype_reg;
                            res.tunnel_id      = teid_reg ? hlow_next[55:24] : 32'd0;
                            res.sequence_res   = teid_reg ? hlow_next[23:0] : hlow_next[31:8];
                            res.message_length = mend_reg;
                            push_o.first = res;
                            n            = 2'd1;
                            ne = next_element(p, mend_reg, found_reg);
                            phase_next = ne.ph;
                            if (ne.ovr) pend_next = gtp2ie_pkg::ST_EHDR_OVR;
                            if (ne.ph == PH_EHDR) begin
                                eend_next = ne.eend;
                                ehb_next  = '0;
                            end
                        end
                    end
                end
                PH_EHDR: begin
                    if (idx != 2'd3) begin
                        ehb_next = {ehb_reg[15:0], in_byte};
                    end else if (vend > {1'b0, mend_reg}) begin
                        pend_next  = gtp2ie_pkg::ST_VALUE_OVR;
                        phase_next = PH_SKIP;
                    end else begin
                        found_next           = found_reg + 6'd1;
                        res                  = '0;
                        res.kind             = gtp2ie_pkg::KIND_ELEMENT;
                        res.element_type     = ehb_reg[23:16];
                        res.element_instance = in_byte[3:0];
                        res.element_length   = el;
                        res.value_offset     = voff[16:0];
                        res.element_count    = found_next;
                        push_o.first = res;
                        n            = 2'd1;
                        eend_next    = vend[16:0];
                        if (el == 16'd0) begin
                            ne = next_element(p, mend_reg, found_next);
                            phase_next = ne.ph;
                            if (ne.ovr) pend_next = gtp2ie_pkg::ST_EHDR_OVR;
                            if (ne.ph == PH_EHDR) begin
                                eend_next = ne.eend;
                                ehb_next  = '0;
                            end
                        end else if (found_next >= 6'(MAX_ELEMENTS)) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    if (voff == {1'b0, eend_reg}) begin
                        ne = next_element(p, mend_reg, found_reg);
                        phase_next = ne.ph;
                        if (ne.ovr) pend_next = gtp2ie_pkg::ST_EHDR_OVR;
                        if (ne.ph == PH_EHDR) begin
                            eend_next = ne.eend;
                            ehb_next  = '0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (phase_next != PH_DRAIN) begin
                if (p >= 17'd3 && voff == {1'b0, mend_next}) begin
                    res        = end_result(found_next, pend_next);
                    phase_next = PH_DRAIN;
                end else if (in_final) begin
                    res = end_result(found_next, gtp2ie_pkg::ST_TRUNC);
                end else begin
                    pos_next = voff[16:0];
                end
                if (phase_next == PH_DRAIN || in_final) begin
                    if (n == 2'd0) push_o.first  = res;
                    else           push_o.second = res;
                    n = n + 2'd1;
                end
            end

            if (n == 2'd1) push_o.first.last_of_run  = 1'b1;
            if (n == 2'd2) push_o.second.last_of_run = 1'b1;
        end
        push_o.cnt = n;

        // the final byte of a buffer returns the parser to its reset state
        if (in_valid && in_final) begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            teid_next  = 1'b0;
            mend_next  = '0;
            mtype_next = '0;
            hlow_next  = '0;
            ehb_next   = '0;
            eend_next  = '0;
            found_next = '0;
            pend_next  = gtp2ie_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            teid_reg  <= 1'b0;
            mend_reg  <= '0;
            mtype_reg <= '0;
            hlow_reg  <= '0;
            ehb_reg   <= '0;
            eend_reg  <= '0;
            found_reg <= '0;
            pend_reg  <= gtp2ie_pkg::ST_OK;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            teid_reg  <= teid_next;
            mend_reg  <= mend_next;
            mtype_reg <= mtype_next;
            hlow_reg  <= hlow_next;
            ehb_reg   <= ehb_next;
            eend_reg  <= eend_next;
            found_reg <= found_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: src/gtp2ie_fifo.sv
// ============================================================================
// GTPv2 header/IE parser result queue
// Small queue taking up to two results per cycle and releasing one on each pop.
// ============================================================================
`include "gtpv2_header_ie_parser_top_defines.svh"

module gtp2ie_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gtp2ie_pkg::push_t     push_i,
    output logic                  room_o,
    output logic                  valid_o,
    input  logic                  pop_i,
    output gtp2ie_pkg::result_t   data_o
);

    localparam int AW = gtp2ie_pkg::QAW;
    localparam int CW = gtp2ie_pkg::QCW;

    gtp2ie_pkg::result_t mem [gtp2ie_pkg::QDEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;

    assign pop     = pop_i && (count_reg != '0);
    assign valid_o = (count_reg != '0);
    assign data_o  = mem[rd_ptr_reg];
    // room for a byte that raises two results
    assign room_o  = (count_reg <= CW'(gtp2ie_pkg::QDEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push_i.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push_i.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_i.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_i.first;
        end
        if (push_i.cnt == 2'd2) begin
            mem[wr_ptr_reg + AW'(1)] <= push_i.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `GTP2IE_ASSERT(a_count_max, aclk, aresetn, count_reg <= CW'(gtp2ie_pkg::QDEPTH), "queue count above depth")
    `GTP2IE_ASSERT(a_no_overflow, aclk, aresetn, (CW'(push_i.cnt) + count_reg) <= (CW'(gtp2ie_pkg::QDEPTH) + CW'(pop)), "push into full queue")
    `GTP2IE_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && push_i.cnt == 2'd0, count_reg == $past(count_reg) - CW'(1), "pop did not drop count")

endmodule

FILE: src/gtpv2_header_ie_parser_top.sv
// Results of an accepted byte are written to the result queue, behind any queued
// before. One byte per cycle in while s_tready is high; one result per cycle out
// while m_tready is high. A byte may raise two results (header or element plus end
// status), held in the 4-entry result queue; s_tready drops with under two free.
// Reset: aresetn, synchronous active low, clears parse state and the queue.
// ============================================================================
// GTPv2 header/IE parser top level
// Byte-stream GTPv2-C header and information element descriptor extraction.
// ============================================================================
module gtpv2_header_ie_parser_top #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // final_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] message_type, [39:8] tunnel_id, [63:40] sequence_res,
    // [80:64] message_length, [88:81] element_type, [92:89] element_instance,
    // [108:93] element_length, [125:109] value_offset, [131:126] element_count,
    // [134:132] status, [135] zero
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast    // last_of_run
);

    gtp2ie_pkg::push_t   push;
    gtp2ie_pkg::result_t res;
    logic                room;
    logic                in_xfer;

    assign s_tready = room;
    assign in_xfer  = s_tvalid && room;

    gtp2ie_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_xfer),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .push_o   (push)
    );

    gtp2ie_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .room_o  (room),
        .valid_o (m_tvalid),
        .pop_i   (m_tready),
        .data_o  (res)
    );

    assign m_tdata = {1'b0, res.status, res.element_count, res.value_offset,
                      res.element_length, res.element_instance, res.element_type,
                      res.message_length, res.sequence_res, res.tunnel_id,
                      res.message_type};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_run;

endmodule
